>>> rtl/core/malu_pkg.sv
// ----------------------------------------------------------------------------
// malu_pkg
// Shared types and codes for the 31-bit modular arithmetic unit.
// ----------------------------------------------------------------------------
package malu_pkg;

	localparam int MOD_WIDTH = 31;
	localparam int EXP_WIDTH = 63;

	typedef enum logic [2:0] {
		OP_ADD    = 3'd0,
		OP_SUB    = 3'd1,
		OP_MUL    = 3'd2,
		OP_DIV    = 3'd3,
		OP_NEG    = 3'd4,
		OP_INV    = 3'd5,
		OP_POW    = 3'd6,
		OP_REDUCE = 3'd7
	} opcode_t;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_INV0  = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;

	localparam logic [30:0] MODULUS_RESET = 31'd1000000007;

endpackage

>>> rtl/core/modular_alu_31bit_unit.sv
// ----------------------------------------------------------------------------
// modular_alu_31bit_unit
// Modular add, sub, mul, div, neg, inv, pow and reduce over a configured
// modulus.
// ----------------------------------------------------------------------------
// One item is in work at a time; in_stall is high until its result has been
// taken. Every modular product goes through one shared multiplier and one
// bit-serial reducer that loads the 64-bit dividend and then works through it
// bit by bit. Add, sub and neg are done in the check state; mul and reduce
// take one pass of the reducer. Pow spends a square, and a multiply where the
// bit is set, on each exponent bit, up to 63 bits; inv and div walk the 31-bit
// exponent modulus-2, and div adds one more reduction.
// ----------------------------------------------------------------------------
module modular_alu_31bit_unit
	import malu_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [30:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  opcode,
	input  logic [30:0] operand_a,
	input  logic [30:0] operand_b,
	input  logic [62:0] exponent,
	input  logic [63:0] signed_value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [30:0] result,
	output logic [1:0]  status
);

	localparam int MW = MOD_WIDTH;
	localparam int EW = (EXP_WIDTH > MOD_WIDTH) ? EXP_WIDTH : MOD_WIDTH;
	localparam int IW = $clog2(EW + 1);

	typedef enum logic [3:0] {
		S_IDLE, S_CHECK, S_ACC_RUN, S_ACC_WAIT, S_SQ_RUN, S_SQ_WAIT,
		S_FIN_RUN, S_FIN_WAIT, S_RED_WAIT, S_OUT
	} state_t;

	state_t        state_q;
	logic [30:0]   modulus_q;
	opcode_t       op_q;
	logic [MW-1:0] a_q, b_q, m_q;
	logic [EW-1:0] e_q;
	logic [IW-1:0] idx_q;
	logic [MW-1:0] acc_q, base_q;
	logic [63:0]   v_q;
	logic [30:0]   res_q;
	logic [1:0]    st_q;

	logic          red_start;
	logic [63:0]   red_in;
	logic          red_done;
	logic [MW-1:0] red_out;

	logic [MW-1:0]   mul_x, mul_y;
	logic [2*MW-1:0] mul_p;
	logic            sel_v;
	logic [MW:0]     add_sum;
	logic            accept;
	logic [MW-1:0]   m_in;
	logic            bad;

	malu_modred #(.MW(MW), .DW(64)) u_red (
		.clk(clk), .arst_n(arst_n), .start(red_start), .dividend(red_in),
		.modulus(m_q), .done(red_done), .remainder(red_out)
	);

	assign accept    = in_valid && !in_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign result    = res_q;
	assign status    = st_q;
	assign m_in      = modulus_q[MW-1:0];
	assign add_sum   = {1'b0, a_q} + {1'b0, b_q};

	always_comb begin
		bad = (m_q == '0)
			|| ((op_q != OP_REDUCE) && (a_q >= m_q))
			|| ((op_q == OP_ADD || op_q == OP_SUB || op_q == OP_MUL || op_q == OP_DIV)
				&& (b_q >= m_q));
	end

	// one shared multiplier feeds the reducer
	always_comb begin
		red_start = 1'b0;
		sel_v     = 1'b0;
		mul_x     = acc_q;
		mul_y     = base_q;
		case (state_q)
			S_CHECK: begin
				red_start = (op_q == OP_MUL || op_q == OP_REDUCE);
				sel_v     = (op_q == OP_REDUCE);
				mul_x     = a_q;
				mul_y     = b_q;
			end
			S_ACC_RUN: red_start = 1'b1;
			S_SQ_RUN: begin
				red_start = 1'b1;
				mul_x     = base_q;
			end
			S_FIN_RUN: begin
				red_start = 1'b1;
				mul_x     = a_q;
				mul_y     = acc_q;
			end
			default: ;
		endcase
		mul_p  = mul_x * mul_y;
		red_in = sel_v ? (v_q[63] ? (~v_q + 64'd1) : v_q) : 64'(mul_p);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			modulus_q <= MODULUS_RESET;
		end else begin
			if (cfg_we)
				modulus_q <= cfg_wdata;
			case (state_q)
				S_IDLE: if (accept) begin
					op_q    <= opcode_t'(opcode);
					a_q     <= MW'(operand_a);
					b_q     <= MW'(operand_b);
					e_q     <= EW'(exponent);
					v_q     <= signed_value;
					m_q     <= m_in;
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					acc_q <= (m_q == MW'(1)) ? '0 : MW'(1);
					idx_q <= '0;
					if (bad) begin
						res_q   <= '0;
						st_q    <= ST_RANGE;
						state_q <= S_OUT;
					end else begin
						case (op_q)
							OP_ADD: begin
								res_q   <= 31'((add_sum >= {1'b0, m_q})
									? add_sum - {1'b0, m_q} : add_sum);
								st_q    <= ST_OK;
								state_q <= S_OUT;
							end
							OP_SUB: begin
								res_q   <= 31'((a_q >= b_q) ? a_q - b_q
									: MW'(add_sum - {1'b0, b_q} - {1'b0, b_q}
									+ {1'b0, m_q}));
								st_q    <= ST_OK;
								state_q <= S_OUT;
							end
							OP_NEG: begin
								res_q   <= 31'((a_q == '0) ? '0 : m_q - a_q);
								st_q    <= ST_OK;
								state_q <= S_OUT;
							end
							OP_MUL, OP_REDUCE: begin
								st_q    <= ST_OK;
								state_q <= S_RED_WAIT;
							end
							OP_DIV: begin
								if (b_q == '0) begin
									res_q   <= '0;
									st_q    <= ST_INV0;
									state_q <= S_OUT;
								end else begin
									st_q    <= ST_OK;
									base_q  <= b_q;
									e_q     <= EW'(m_q - MW'(2));
									state_q <= S_ACC_RUN;
								end
							end
							OP_INV: begin
								if (a_q == '0) begin
									res_q   <= '0;
									st_q    <= ST_INV0;
									state_q <= S_OUT;
								end else begin
									st_q    <= ST_OK;
									base_q  <= a_q;
									e_q     <= EW'(m_q - MW'(2));
									state_q <= S_ACC_RUN;
								end
							end
							OP_POW: begin
								st_q    <= ST_OK;
								base_q  <= a_q;
								state_q <= S_ACC_RUN;
							end
							default: begin
								res_q   <= '0;
								st_q    <= ST_OK;
								state_q <= S_OUT;
							end
						endcase
					end
				end
				S_ACC_RUN: begin
					state_q <= e_q[0] ? S_ACC_WAIT : S_SQ_RUN;
				end
				S_ACC_WAIT: if (red_done) begin
					acc_q   <= red_out;
					state_q <= S_SQ_RUN;
				end
				S_SQ_RUN: state_q <= S_SQ_WAIT;
				S_SQ_WAIT: if (red_done) begin
					base_q <= red_out;
					e_q    <= e_q >> 1;
					idx_q  <= idx_q + IW'(1);
					if (idx_q == IW'(EW - 1) || (e_q >> 1) == '0) begin
						if (op_q == OP_DIV) state_q <= S_FIN_RUN;
						else begin
							res_q   <= 31'(acc_q);
							state_q <= S_OUT;
						end
					end else
						state_q <= S_ACC_RUN;
				end
				S_FIN_RUN: state_q <= S_FIN_WAIT;
				S_FIN_WAIT: if (red_done) begin
					res_q   <= 31'(red_out);
					state_q <= S_OUT;
				end
				S_RED_WAIT: if (red_done) begin
					if (op_q == OP_REDUCE && v_q[63] && red_out != '0)
						res_q <= 31'(m_q - red_out);
					else
						res_q <= 31'(red_out);
					state_q <= S_OUT;
				end
				S_OUT: if (!out_stall) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

>>> rtl/core/malu_modred.sv
// ----------------------------------------------------------------------------
// malu_modred
// Bit-serial modular reduction: remainder of an unsigned value by the modulus,
// one dividend bit per cycle (shift, compare, subtract).
// ----------------------------------------------------------------------------
module malu_modred #(
	parameter int MW = 31,
	parameter int DW = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [MW-1:0] modulus,
	output logic          done,
	output logic [MW-1:0] remainder
);

	localparam int CW = $clog2(DW + 1);

	logic [DW-1:0] shift_q;
	logic [MW:0]   rem_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic [MW:0]   trial;

	always_comb begin
		trial = {rem_q[MW-1:0], shift_q[DW-1]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q  <= 1'b1;
				shift_q <= dividend;
				rem_q   <= '0;
				cnt_q   <= CW'(DW);
			end else if (busy_q) begin
				shift_q <= {shift_q[DW-2:0], 1'b0};
				if (trial >= {1'b0, modulus})
					rem_q <= trial - {1'b0, modulus};
				else
					rem_q <= trial;
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	assign remainder = rem_q[MW-1:0];

endmodule

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for modular_alu_31bit_unit. Items go through the
// valid/stall input channel under random gaps and the results are compared
// with a predictor of the modular arithmetic. The modulus is swept over
// primes, small and extreme values, zero and one. The receiver stalls at
// random and once holds off long enough to back up the input.
// ----------------------------------------------------------------------------
module tb;
	import malu_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDLE_LIMIT = 50000;

	typedef struct {
		opcode_t     op;
		bit [30:0]   a;
		bit [30:0]   b;
		bit [62:0]   e;
		bit [63:0]   v;
	} alu_item_t;

	typedef struct {
		bit [30:0] res;
		bit [1:0]  st;
	} alu_result_t;

	class alu_scoreboard;
		bit [30:0]   modulus = MODULUS_RESET;
		alu_result_t pending[$];
		int          errors = 0;

		function longint unsigned mulmod(longint unsigned x, longint unsigned y,
				longint unsigned m);
			return (x * y) % m;
		endfunction

		function longint unsigned powmod(longint unsigned base, longint unsigned ex,
				longint unsigned m);
			longint unsigned acc;
			acc = 1 % m;
			base = base % m;
			for (int i = 0; i < 63; i++) begin
				if (ex[i])
					acc = mulmod(acc, base, m);
				base = mulmod(base, base, m);
			end
			return acc;
		endfunction

		function void note_input(alu_item_t it);
			longint unsigned m, a, b, r, res;
			bit [1:0]        st;
			alu_result_t     x;
			m = modulus;
			a = it.a;
			b = it.b;
			res = 0;
			st = ST_OK;
			if (m == 0 || (it.op != OP_REDUCE && a >= m) || (it.op <= OP_DIV && b >= m)) begin
				st = ST_RANGE;
			end else begin
				case (it.op)
					OP_ADD: res = (a + b) % m;
					OP_SUB: res = (a >= b) ? a - b : a + m - b;
					OP_MUL: res = mulmod(a, b, m);
					OP_DIV: begin
						if (b == 0) st = ST_INV0;
						else res = mulmod(a, powmod(b, m - 2, m), m);
					end
					OP_NEG: res = (a == 0) ? 0 : m - a;
					OP_INV: begin
						if (a == 0) st = ST_INV0;
						else res = powmod(a, m - 2, m);
					end
					OP_POW: res = powmod(a, it.e, m);
					default: begin
						if (it.v[63]) begin
							r = (~it.v + 64'd1) % m;
							res = (r == 0) ? 0 : m - r;
						end else begin
							res = it.v % m;
						end
					end
				endcase
			end
			if (st != ST_OK)
				res = 0;
			x.res = res[30:0];
			x.st = st;
			pending.push_back(x);
		endfunction

		task report(string msg);
			$display("mismatch: %s", msg);
			errors++;
		endtask

		task check_result(bit [30:0] res, bit [1:0] st);
			alu_result_t x;
			if (pending.size() == 0) begin
				report($sformatf("unexpected result %0d status %0d", res, st));
			end else begin
				x = pending.pop_front();
				if (res !== x.res)
					report($sformatf("result %0d, expected %0d", res, x.res));
				if (st !== x.st)
					report($sformatf("status %0d, expected %0d", st, x.st));
			end
		endtask
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        cfg_we = 0;
	logic [30:0] cfg_wdata = '0;
	logic        in_valid = 0;
	logic        in_stall;
	logic [2:0]  opcode = '0;
	logic [30:0] operand_a = '0;
	logic [30:0] operand_b = '0;
	logic [62:0] exponent = '0;
	logic [63:0] signed_value = '0;
	logic        out_valid;
	logic        out_stall = 0;
	logic [30:0] result;
	logic [1:0]  status;

	alu_scoreboard sb = new();
	int            hold_cycles = 0;
	int            idle_cycles = 0;
	bit            sent_hold = 0;

	modular_alu_31bit_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall),
		.opcode(opcode), .operand_a(operand_a), .operand_b(operand_b),
		.exponent(exponent), .signed_value(signed_value),
		.out_valid(out_valid), .out_stall(out_stall),
		.result(result), .status(status)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 55) return 0;
		if (p < 90) return $urandom_range(1, 4);
		return $urandom_range(10, 80);
	endfunction

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		int n;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				out_stall = 1;
				hold_cycles--;
			end else if (n > 0) begin
				out_stall = 1;
				n--;
			end else begin
				n = gap_len();
				out_stall = (n > 0);
				if (n > 0) n--;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(result, status);
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	task send_item(alu_item_t it);
		int g;
		g = gap_len();
		if (g > 0) begin
			@(negedge clk);
			in_valid = 0;
			repeat (g - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid = 1;
		opcode = it.op;
		operand_a = it.a;
		operand_b = it.b;
		exponent = it.e;
		signed_value = it.v;
		do @(posedge clk); while (in_stall);
		sb.note_input(it);
	endtask

	task set_modulus(bit [30:0] m);
		@(negedge clk);
		in_valid = 0;
		wait (sb.pending.size() == 0);
		repeat (10) @(negedge clk);
		cfg_we = 1;
		cfg_wdata = m;
		@(negedge clk);
		cfg_we = 0;
		sb.modulus = m;
	endtask

	function alu_item_t mk(opcode_t op, bit [30:0] a, bit [30:0] b, bit [62:0] e,
			bit [63:0] v);
		alu_item_t it;
		it.op = op; it.a = a; it.b = b; it.e = e; it.v = v;
		return it;
	endfunction

	function bit [30:0] rand_opnd(bit [30:0] m);
		if (m == 0 || $urandom_range(0, 9) == 0)
			return 31'($urandom());
		if ($urandom_range(0, 9) == 0)
			return ($urandom_range(0, 1)) ? m - 31'd1 : 31'd0;
		return 31'($urandom() % m);
	endfunction

	function alu_item_t rand_item(bit [30:0] m);
		alu_item_t it;
		int        p;
		p = $urandom_range(0, 99);
		if (p < 14) it.op = OP_ADD;
		else if (p < 28) it.op = OP_SUB;
		else if (p < 44) it.op = OP_MUL;
		else if (p < 52) it.op = OP_DIV;
		else if (p < 64) it.op = OP_NEG;
		else if (p < 71) it.op = OP_INV;
		else if (p < 81) it.op = OP_POW;
		else it.op = OP_REDUCE;
		it.a = rand_opnd(m);
		it.b = rand_opnd(m);
		it.e = 63'({$urandom(), $urandom()});
		if ($urandom_range(0, 1)) it.e = it.e >> $urandom_range(0, 62);
		it.v = {$urandom(), $urandom()};
		return it;
	endfunction

	task run_random(bit [30:0] m, int count);
		for (int i = 0; i < count; i++) begin
			if (!sent_hold && i == count / 2) begin
				hold_cycles = 400;
				sent_hold = 1;
			end
			send_item(rand_item(m));
		end
	endtask

	initial begin
		bit [30:0] mods[7];
		int        counts[7];
		mods = '{31'd998244353, 31'd2, 31'h7FFFFFFF, 31'd0, 31'd1, 31'd15, 31'd97};
		counts = '{25, 12, 25, 8, 8, 15, 20};
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed, reset modulus
		send_item(mk(OP_ADD, 31'd1000000006, 31'd1000000006, '0, '0));
		send_item(mk(OP_SUB, 31'd0, 31'd1000000006, '0, '0));
		send_item(mk(OP_SUB, 31'd5, 31'd3, '0, '0));
		send_item(mk(OP_MUL, 31'd1000000006, 31'd1000000006, '0, '0));
		send_item(mk(OP_DIV, 31'd12345, 31'd0, '0, '0));
		send_item(mk(OP_DIV, 31'd12345, 31'd678, '0, '0));
		send_item(mk(OP_NEG, 31'd0, '0, '0, '0));
		send_item(mk(OP_NEG, 31'd1, '0, '0, '0));
		send_item(mk(OP_INV, 31'd0, '0, '0, '0));
		send_item(mk(OP_INV, 31'd2, '0, '0, '0));
		send_item(mk(OP_POW, 31'd0, '0, '0, '0));
		send_item(mk(OP_POW, 31'd3, '0, '1, '0));
		send_item(mk(OP_REDUCE, '0, '0, '0, 64'h8000000000000000));
		send_item(mk(OP_REDUCE, '0, '0, '0, 64'h7FFFFFFFFFFFFFFF));
		send_item(mk(OP_REDUCE, '0, '0, '0, '1));
		send_item(mk(OP_REDUCE, '1, '1, '0, 64'd0));
		send_item(mk(OP_ADD, 31'h7FFFFFFF, 31'd1, '0, '0));
		send_item(mk(OP_MUL, 31'd1, 31'd1000000007, '0, '0));
		send_item(mk(OP_INV, 31'h7FFFFFFF, '0, '0, '0));
		send_item(mk(OP_DIV, 31'd1000000007, 31'd0, '0, '0));
		send_item(mk(OP_NEG, 31'd1000000007, '1, '0, '0));
		run_random(MODULUS_RESET, 10);

		for (int k = 0; k < 7; k++) begin
			set_modulus(mods[k]);
			run_random(mods[k], counts[k]);
		end
		set_modulus(MODULUS_RESET);
		run_random(MODULUS_RESET, 10);

		@(negedge clk);
		in_valid = 0;
		wait (sb.pending.size() == 0);
		repeat (100) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule
